>>> rtl/pctt_pkg.sv
`default_nettype none
package pctt_pkg;

  localparam int Slots = 16;
  localparam int SlotW = 5;
  localparam int IdxW = 4;
  localparam logic [SlotW-1:0] SlotNone = 5'd16;
  localparam logic [47:0] Max48 = 48'hFFFF_FFFF_FFFF;

  localparam logic [2:0] KAllocPer = 3'd0;
  localparam logic [2:0] KAllocOne = 3'd1;
  localparam logic [2:0] KStop = 3'd2;
  localparam logic [2:0] KFree = 3'd3;
  localparam logic [2:0] KRun = 3'd4;
  localparam logic [2:0] KStopAll = 3'd5;
  localparam logic [2:0] KClearAll = 3'd6;
  localparam logic [2:0] KUnused = 3'd7;

  localparam logic [2:0] TStart = 3'd0;
  localparam logic [2:0] TExec = 3'd1;
  localparam logic [2:0] TOnce = 3'd2;
  localparam logic [2:0] TStop = 3'd3;
  localparam logic [2:0] TFree = 3'd4;

  localparam logic [2:0] StOk = 3'd0;
  localparam logic [2:0] StDup = 3'd1;
  localparam logic [2:0] StFull = 3'd2;
  localparam logic [2:0] StRej = 3'd3;
  localparam logic [2:0] StFire = 3'd4;

  typedef struct packed {
    logic [2:0] kind;
    logic [15:0] callback_id;
    logic signed [31:0] user_arg;
    logic [15:0] interval_ms;
    logic [47:0] first_due;
    logic [47:0] now_time;
    logic [4:0] held_slot;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [4:0] slot;
    logic [15:0] fire_callback;
    logic signed [31:0] fire_arg;
    logic [2:0] call_type;
    logic last;
  } out_item_t;

endpackage
`default_nettype wire

>>> rtl/periodic_callback_timer_table.sv
// Periodic callback timer table.
// Input channel (in_valid_i/in_ready_o, in_item_i) takes one command item:
// allocate, stop, free, run due, stop all or clear all. Output channel
// (out_valid_o/out_ready_i, out_item_o) returns results; each command gives
// one result with last set, except run due, which gives one fire result per
// due slot and then a done result with last set.
// The block holds one command at a time. A slot sequencer walks the 16 slots
// one per cycle, unless a result waits, through a single shared compare/add
// unit. After an item is accepted, the prep state checks the held slot and
// forms the interval product, the scan steps over the slots (up to all 16)
// and, if it reaches the end, forms the done or full result, the out state
// raises the final result and the done state completes its handshake.
// An allocation stops at the first free or matching slot; stop, free and
// rejected items skip the scan. A receiver stall on the output delays the
// next item.
// When the receiver stalls, the scan pauses on the pending result; nothing
// is dropped. Reset frees every slot and sets ticks_per_ms to 1000.
// cfg_we_i writes ticks_per_ms at once; write it only while idle.
`default_nettype none
module periodic_callback_timer_table import pctt_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      cfg_we_i,
  input  wire logic [20:0] cfg_wdata_i,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_item_o
);

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SPrep = 3'd1;
  localparam logic [2:0] SScan = 3'd2;
  localparam logic [2:0] SOut = 3'd3;
  localparam logic [2:0] SDone = 3'd4;

  logic [2:0] state_q;
  in_item_t cmd_q;
  logic [IdxW:0] idx_q;
  logic [20:0] tpm_q;
  logic [47:0] ivl_q;
  logic out_valid_q;
  out_item_t out_q;

  logic [15:0] cb_q [Slots];
  logic [31:0] arg_q [Slots];
  logic [2:0] ty_q [Slots];
  logic [47:0] iv_q [Slots];
  logic [47:0] due_q [Slots];

  logic [IdxW-1:0] i;
  logic [IdxW-1:0] h;
  logic held_ok;
  logic [48:0] sum;
  logic is_alloc, once, match, free_s, fire;
  logic out_free, out_set;

  assign i = idx_q[IdxW-1:0];
  assign h = cmd_q.held_slot[IdxW-1:0];
  assign held_ok = cmd_q.held_slot < SlotW'(Slots);
  assign is_alloc = (cmd_q.kind == KAllocPer) || (cmd_q.kind == KAllocOne);
  assign once = cmd_q.kind == KAllocOne;
  assign match = (cb_q[i] == cmd_q.callback_id) && (arg_q[i] == cmd_q.user_arg);
  assign free_s = cb_q[i] == 16'd0;
  assign fire = !free_s && (ty_q[i] != TFree) && (due_q[i] <= cmd_q.now_time);
  // shared adder for due advance
  assign sum = {1'b0, due_q[i]} + {1'b0, iv_q[i]};

  assign in_ready_o = state_q == SIdle;
  assign out_valid_o = out_valid_q;
  assign out_item_o = out_q;

  // raise valid on a fire result or on the final result
  assign out_free = !out_valid_q || out_ready_i;
  assign out_set = out_free &&
                   (((state_q == SScan) && (idx_q != (IdxW+1)'(Slots)) &&
                     (cmd_q.kind == KRun) && fire) || (state_q == SOut));

  function automatic out_item_t res(logic [2:0] st, logic [4:0] sl);
    out_item_t r;
    r = '0;
    r.status = st;
    r.slot = sl;
    r.last = 1'b1;
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_set) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      idx_q <= '0;
      tpm_q <= 21'd1000;
      cmd_q <= '0;
      ivl_q <= '0;
      out_q <= '0;
      for (int k = 0; k < Slots; k++) begin
        cb_q[k] <= '0; arg_q[k] <= '0; ty_q[k] <= '0; iv_q[k] <= '0; due_q[k] <= '0;
      end
    end else begin
      if (cfg_we_i) tpm_q <= cfg_wdata_i;
      case (state_q)
        SIdle: begin
          if (in_valid_i) begin
            cmd_q <= in_item_i;
            idx_q <= '0;
            state_q <= SPrep;
          end
        end
        SPrep: begin
          // one multiply, then decide trivial commands
          ivl_q <= {11'd0, 37'(cmd_q.interval_ms) * 37'(tpm_q)};
          state_q <= SScan;
          if (is_alloc) begin
            if (cmd_q.callback_id == 16'd0 || (!once && cmd_q.interval_ms == 16'd0) ||
                (!once && held_ok && cb_q[h] != 16'd0)) begin
              out_q <= res(StRej, SlotNone);
              state_q <= SOut;
            end
          end else if (cmd_q.kind == KStop || cmd_q.kind == KFree) begin
            if (!held_ok) out_q <= res(StRej, SlotNone);
            else begin
              ty_q[h] <= (cmd_q.kind == KStop) ? TStop : TFree;
              out_q <= res(StOk, cmd_q.held_slot);
            end
            state_q <= SOut;
          end else if (cmd_q.kind != KRun && cmd_q.kind != KStopAll &&
                       cmd_q.kind != KClearAll) begin
            out_q <= res(StRej, SlotNone);
            state_q <= SOut;
          end
        end
        SScan: begin
          // one slot per cycle; pause while a result waits
          if (!(out_valid_q && !out_ready_i)) begin
            if (idx_q == (IdxW+1)'(Slots)) begin
              out_q <= is_alloc ? res(StFull, SlotNone) : res(StOk, SlotNone);
              state_q <= SOut;
            end else begin
              idx_q <= idx_q + 1'b1;
              case (cmd_q.kind)
                KAllocPer, KAllocOne: begin
                  if (match) begin
                    out_q <= res(StDup, once ? {1'b0, i} : SlotNone);
                    state_q <= SOut;
                  end else if (free_s) begin
                    cb_q[i] <= cmd_q.callback_id;
                    arg_q[i] <= cmd_q.user_arg;
                    ty_q[i] <= once ? TOnce : TStart;
                    iv_q[i] <= once ? 48'd0 : ivl_q;
                    due_q[i] <= (cmd_q.first_due == 48'd0) ? cmd_q.now_time
                                                          : cmd_q.first_due;
                    out_q <= res(StOk, {1'b0, i});
                    state_q <= SOut;
                  end
                end
                KRun: begin
                  if (fire) begin
                    out_q.status <= StFire;
                    out_q.slot <= {1'b0, i};
                    out_q.fire_callback <= cb_q[i];
                    out_q.fire_arg <= arg_q[i];
                    out_q.call_type <= ty_q[i];
                    out_q.last <= 1'b0;
                    if (ty_q[i] == TOnce || ty_q[i] == TStop) begin
                      cb_q[i] <= '0; arg_q[i] <= '0; ty_q[i] <= '0;
                      iv_q[i] <= '0; due_q[i] <= '0;
                    end else begin
                      due_q[i] <= sum[48] ? Max48 : sum[47:0];
                      if (ty_q[i] == TStart) ty_q[i] <= TExec;
                    end
                  end
                end
                KStopAll: begin
                  if (!free_s) begin
                    due_q[i] <= cmd_q.now_time;
                    ty_q[i] <= TStop;
                  end
                end
                default: begin
                  cb_q[i] <= '0; arg_q[i] <= '0; ty_q[i] <= '0;
                  iv_q[i] <= '0; due_q[i] <= '0;
                end
              endcase
            end
          end
        end
        SOut: begin
          // present the final result once the output is free
          if (!(out_valid_q && !out_ready_i)) begin
            state_q <= SDone;
          end
        end
        SDone: begin
          if (out_ready_i) state_q <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> rtl/pctt_checker.sv
`default_nettype none
module pctt_checker import pctt_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_o,
  input wire logic out_valid_o,
  input wire logic out_ready_i,
  input wire out_item_t out_item_o
);
  // hold a stalled result
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");
  // no new item accepted while a result is pending
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("ready while result pending");
  // accepted item drops ready
  a_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o) else $error("ready after accept");
  // fire results are never last
  a_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status == StFire |-> !out_item_o.last)
    else $error("fire marked last");
endmodule

bind periodic_callback_timer_table pctt_checker u_chk (.*);
`default_nettype wire
